// ===== sv/vna_pkg.sv =====
// Package for the vertex normal accumulator: payload structs, function and
// datapath operation codes, and the controller/datapath command and status types.
// No dependencies.
package vna_pkg;

    localparam int IDX_W   = 10;
    localparam int FIELD_W = 16;
    localparam int NORM_W  = 16;

    // Normalized magnitudes land in [2^NORM_LO, 2^NORM_HI).
    localparam int NORM_HI = 30;
    localparam int NORM_LO = 29;
    localparam int MAG_W   = NORM_HI;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ACC_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int DIV_W   = 48;
    localparam int Q_W     = 16;
    localparam int Q_FRAC  = 15;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_TRI   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NEW   = 2'd3;

    localparam logic signed [NORM_W-1:0] Q_ONE = 16'sd16384;

    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_CAPTURE   = 5'd1;
    localparam logic [4:0] OP_LOAD      = 5'd2;
    localparam logic [4:0] OP_CLEAR     = 5'd3;
    localparam logic [4:0] OP_POS_RD    = 5'd4;
    localparam logic [4:0] OP_POS_CAP   = 5'd5;
    localparam logic [4:0] OP_EDGE      = 5'd6;
    localparam logic [4:0] OP_MUL       = 5'd7;
    localparam logic [4:0] OP_CR_ACC    = 5'd8;
    localparam logic [4:0] OP_SUM_RD    = 5'd9;
    localparam logic [4:0] OP_SUM_WR    = 5'd10;
    localparam logic [4:0] OP_Q_LOAD    = 5'd11;
    localparam logic [4:0] OP_NORM      = 5'd12;
    localparam logic [4:0] OP_SQ_MUL    = 5'd13;
    localparam logic [4:0] OP_SQ_ACC    = 5'd14;
    localparam logic [4:0] OP_SQRT_INIT = 5'd15;
    localparam logic [4:0] OP_SQRT      = 5'd16;
    localparam logic [4:0] OP_DIV_INIT  = 5'd17;
    localparam logic [4:0] OP_DIV       = 5'd18;
    localparam logic [4:0] OP_DIV_STORE = 5'd19;
    localparam logic [4:0] OP_OUT       = 5'd20;
    localparam logic [4:0] OP_OUT_DEF   = 5'd21;
    localparam logic [4:0] OP_OUT_BAD   = 5'd22;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic [IDX_W-1:0]          idx_a;
        logic [IDX_W-1:0]          idx_b;
        logic [IDX_W-1:0]          idx_c;
    } t_in;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     used_default;
        logic                     bad_index;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] sel;
        logic [2:0] step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       tri_bad;
        logic       q_bad;
        logic       big_zero;
        logic       need_norm;
        logic       sqrt_last;
        logic       div_last;
        logic       out_full;
    } t_sts;

endpackage

// ===== sv/vna_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vna_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [(D>1?$clog2(D):1)-1:0] i_waddr,
    input  logic [W-1:0]                  i_wdata,
    input  logic                          i_re,
    input  logic [(D>1?$clog2(D):1)-1:0] i_raddr,
    output logic [W-1:0]                  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vna_ctrl.sv =====
// Controller state machine for the vertex normal accumulator.
// Depends on vna_pkg; drives the datapath only through t_cmd and reads t_sts.
module vna_ctrl import vna_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DEC   = 5'd1;
    localparam logic [4:0] ST_T_RD  = 5'd2;
    localparam logic [4:0] ST_T_CAP = 5'd3;
    localparam logic [4:0] ST_T_EDG = 5'd4;
    localparam logic [4:0] ST_T_MUL = 5'd5;
    localparam logic [4:0] ST_T_ACC = 5'd6;
    localparam logic [4:0] ST_T_SRD = 5'd7;
    localparam logic [4:0] ST_T_SWR = 5'd8;
    localparam logic [4:0] ST_Q_RD  = 5'd9;
    localparam logic [4:0] ST_Q_LD  = 5'd10;
    localparam logic [4:0] ST_Q_CHK = 5'd11;
    localparam logic [4:0] ST_Q_SQM = 5'd12;
    localparam logic [4:0] ST_Q_SQA = 5'd13;
    localparam logic [4:0] ST_Q_SQI = 5'd14;
    localparam logic [4:0] ST_Q_SQR = 5'd15;
    localparam logic [4:0] ST_Q_DI  = 5'd16;
    localparam logic [4:0] ST_Q_DIV = 5'd17;
    localparam logic [4:0] ST_Q_DST = 5'd18;
    localparam logic [4:0] ST_Q_OUT = 5'd19;
    localparam logic [4:0] ST_Q_DEF = 5'd20;
    localparam logic [4:0] ST_Q_BAD = 5'd21;

    logic [4:0] r_state, n_state;
    logic [2:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd.op   = OP_NOP;
        o_cmd.sel  = r_k[1:0];
        o_cmd.step = r_k;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = ST_DEC;
                end
            end
            ST_DEC: begin
                n_k = 3'd0;
                case (i_sts.func)
                    FUNC_LOAD: begin
                        if (!i_sts.full) o_cmd.op = OP_LOAD;
                        n_state = ST_IDLE;
                    end
                    FUNC_TRI: begin
                        n_state = i_sts.tri_bad ? ST_IDLE : ST_T_RD;
                    end
                    FUNC_QUERY: begin
                        n_state = i_sts.q_bad ? ST_Q_BAD : ST_Q_RD;
                    end
                    default: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = ST_IDLE;
                    end
                endcase
            end
            ST_T_RD: begin
                o_cmd.op = OP_POS_RD;
                n_state  = ST_T_CAP;
            end
            ST_T_CAP: begin
                o_cmd.op = OP_POS_CAP;
                if (r_k == 3'd2) begin
                    n_state = ST_T_EDG;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_T_RD;
                end
            end
            ST_T_EDG: begin
                o_cmd.op = OP_EDGE;
                n_k      = 3'd0;
                n_state  = ST_T_MUL;
            end
            ST_T_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_T_ACC;
            end
            ST_T_ACC: begin
                o_cmd.op = OP_CR_ACC;
                if (r_k == 3'd5) begin
                    n_k     = 3'd0;
                    n_state = ST_T_SRD;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_T_MUL;
                end
            end
            ST_T_SRD: begin
                o_cmd.op = OP_SUM_RD;
                n_state  = ST_T_SWR;
            end
            ST_T_SWR: begin
                o_cmd.op = OP_SUM_WR;
                if (r_k == 3'd2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_T_SRD;
                end
            end
            ST_Q_RD: begin
                o_cmd.op = OP_SUM_RD;
                n_state  = ST_Q_LD;
            end
            ST_Q_LD: begin
                o_cmd.op = OP_Q_LOAD;
                n_state  = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                n_k = 3'd0;
                if (i_sts.big_zero) begin
                    n_state = ST_Q_DEF;
                end else if (i_sts.need_norm) begin
                    o_cmd.op = OP_NORM;
                end else begin
                    n_state = ST_Q_SQM;
                end
            end
            ST_Q_SQM: begin
                o_cmd.op = OP_SQ_MUL;
                n_state  = ST_Q_SQA;
            end
            ST_Q_SQA: begin
                o_cmd.op = OP_SQ_ACC;
                if (r_k == 3'd2) begin
                    n_state = ST_Q_SQI;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_Q_SQM;
                end
            end
            ST_Q_SQI: begin
                o_cmd.op = OP_SQRT_INIT;
                n_state  = ST_Q_SQR;
            end
            ST_Q_SQR: begin
                o_cmd.op = OP_SQRT;
                if (i_sts.sqrt_last) begin
                    n_k     = 3'd0;
                    n_state = ST_Q_DI;
                end
            end
            ST_Q_DI: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = ST_Q_DIV;
            end
            ST_Q_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_last) n_state = ST_Q_DST;
            end
            ST_Q_DST: begin
                o_cmd.op = OP_DIV_STORE;
                if (r_k == 3'd2) begin
                    n_state = ST_Q_OUT;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_Q_DI;
                end
            end
            ST_Q_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            ST_Q_DEF: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_OUT_DEF;
                    n_state  = ST_IDLE;
                end
            end
            ST_Q_BAD: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = OP_OUT_BAD;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/vna_dp.sv =====
// Datapath for the vertex normal accumulator: vertex and sum memories, cross
// product, saturating sums, normalization, square root and divider.
// Depends on vna_pkg and vna_ram; driven by t_cmd from the controller.
module vna_dp import vna_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16,
    parameter int SUM_BITS     = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam int EW   = COORD_BITS + 1;
    localparam int PW   = 2 * EW;
    localparam int CRW  = PW + 1;
    localparam int TW   = ((CRW > SUM_BITS) ? CRW : SUM_BITS) + 1;
    localparam int RAWW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int PRW  = 3 * COORD_BITS;
    localparam int SRW  = 3 * SUM_BITS + 1;

    localparam logic [ACC_W-1:0]    SQRT_BIT0 = ACC_W'(1) << (ACC_W - 2);
    localparam logic [Q_W-1:0]      QBIT0     = Q_W'(1) << (Q_W - 1);
    localparam logic [Q_W-1:0]      Q_CLAMP   = Q_W'(Q_ONE);
    localparam logic [SUM_BITS-1:0] SUM_HI    = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_LO    = {1'b1, {(SUM_BITS-1){1'b0}}};

    function automatic logic [COORD_BITS-1:0] coord(input logic [FIELD_W-1:0] f);
        logic [RAWW-1:0] raw;
        raw = RAWW'(f);
        return raw[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [EW-1:0] sx(input logic [COORD_BITS-1:0] v);
        return $signed({v[COORD_BITS-1], v});
    endfunction

    // Returns {overflow, clamped sum}.
    function automatic logic [SUM_BITS:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic signed [CRW-1:0] c);
        logic signed [TW-1:0]   t;
        logic [TW-SUM_BITS:0]   top;
        t   = TW'($signed(s)) + TW'(c);
        top = t[TW-1:SUM_BITS-1];
        if ((&top) || !(|top)) begin
            return {1'b0, t[SUM_BITS-1:0]};
        end
        return {1'b1, t[TW-1] ? SUM_LO : SUM_HI};
    endfunction

    t_in                    r_item;
    logic [CW-1:0]          r_count;
    logic [PRW-1:0]         r_pa, r_pb, r_pc;
    logic signed [EW-1:0]   r_e0 [3];
    logic signed [EW-1:0]   r_e1 [3];
    logic signed [PW-1:0]   r_cprod;
    logic signed [CRW-1:0]  r_cr [3];
    logic [SUM_BITS-1:0]    r_m [3];
    logic [2:0]             r_sgn;
    logic                   r_sat;
    logic [SQ_W-1:0]        r_sq;
    logic [ACC_W-1:0]       r_acc, r_x, r_res, r_bit;
    logic [DIV_W-1:0]       r_rem, r_dsh;
    logic [Q_W-1:0]         r_qbit, r_q;
    logic signed [NORM_W-1:0] r_n [3];
    t_out                   r_out;
    logic                   r_out_valid;

    logic [CMPW-1:0]        w_ia, w_ib, w_ic, w_cnt, w_sel_idx;
    logic [AW-1:0]          w_addr;
    logic                   w_full, w_load;
    logic [PRW-1:0]         w_pos_rd;
    logic [SRW-1:0]         w_sum_rd, w_sum_new;
    logic [SUM_BITS:0]      w_ax, w_ay, w_az;
    logic signed [EW-1:0]   w_ma, w_mb;
    logic signed [CRW-1:0]  w_cext;
    logic [SUM_BITS-1:0]    w_big01, w_big, w_s [3];
    logic [MAG_W-1:0]       w_sqop, w_msel;
    logic [ACC_W-1:0]       w_rb;
    logic [ROOT_W-1:0]      w_root;
    logic [Q_W-1:0]         w_qc;
    logic signed [NORM_W-1:0] w_qs;
    logic                   w_sgn_sel;

    assign w_ia   = CMPW'(r_item.idx_a);
    assign w_ib   = CMPW'(r_item.idx_b);
    assign w_ic   = CMPW'(r_item.idx_c);
    assign w_cnt  = CMPW'(r_count);
    assign w_full = (r_count == CW'(MAX_VERTICES));
    assign w_load = (i_cmd.op == OP_LOAD) && !w_full;

    always_comb begin
        case (i_cmd.sel)
            2'd0:    w_sel_idx = w_ia;
            2'd1:    w_sel_idx = w_ib;
            default: w_sel_idx = w_ic;
        endcase
    end
    assign w_addr = w_sel_idx[AW-1:0];

    vna_ram #(.W(PRW), .D(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({coord(r_item.pos_z), coord(r_item.pos_y), coord(r_item.pos_x)}),
        .i_re    (i_cmd.op == OP_POS_RD),
        .i_raddr (w_addr),
        .o_rdata (w_pos_rd)
    );

    // Word layout: {sat flag, sum z, sum y, sum x}.
    vna_ram #(.W(SRW), .D(MAX_VERTICES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_load || (i_cmd.op == OP_SUM_WR)),
        .i_waddr (w_load ? r_count[AW-1:0] : w_addr),
        .i_wdata (w_load ? SRW'(0) : w_sum_new),
        .i_re    (i_cmd.op == OP_SUM_RD),
        .i_raddr (w_addr),
        .o_rdata (w_sum_rd)
    );

    assign w_ax = sat_add(w_sum_rd[SUM_BITS-1:0], r_cr[0]);
    assign w_ay = sat_add(w_sum_rd[2*SUM_BITS-1:SUM_BITS], r_cr[1]);
    assign w_az = sat_add(w_sum_rd[3*SUM_BITS-1:2*SUM_BITS], r_cr[2]);
    assign w_sum_new = {w_sum_rd[SRW-1] | w_ax[SUM_BITS] | w_ay[SUM_BITS] | w_az[SUM_BITS],
                        w_az[SUM_BITS-1:0], w_ay[SUM_BITS-1:0], w_ax[SUM_BITS-1:0]};

    always_comb begin
        case (i_cmd.step)
            3'd0:    begin w_ma = r_e0[1]; w_mb = r_e1[2]; end
            3'd1:    begin w_ma = r_e0[2]; w_mb = r_e1[1]; end
            3'd2:    begin w_ma = r_e0[2]; w_mb = r_e1[0]; end
            3'd3:    begin w_ma = r_e0[0]; w_mb = r_e1[2]; end
            3'd4:    begin w_ma = r_e0[0]; w_mb = r_e1[1]; end
            default: begin w_ma = r_e0[1]; w_mb = r_e1[0]; end
        endcase
    end
    assign w_cext = CRW'(r_cprod);

    assign w_s[0] = w_sum_rd[SUM_BITS-1:0];
    assign w_s[1] = w_sum_rd[2*SUM_BITS-1:SUM_BITS];
    assign w_s[2] = w_sum_rd[3*SUM_BITS-1:2*SUM_BITS];

    assign w_big01 = (r_m[1] > r_m[0]) ? r_m[1] : r_m[0];
    assign w_big   = (r_m[2] > w_big01) ? r_m[2] : w_big01;

    always_comb begin
        case (i_cmd.sel)
            2'd0:    begin w_msel = r_m[0][MAG_W-1:0]; w_sgn_sel = r_sgn[0]; end
            2'd1:    begin w_msel = r_m[1][MAG_W-1:0]; w_sgn_sel = r_sgn[1]; end
            default: begin w_msel = r_m[2][MAG_W-1:0]; w_sgn_sel = r_sgn[2]; end
        endcase
        case (i_cmd.step)
            3'd0:    w_sqop = r_m[0][MAG_W-1:0];
            3'd1:    w_sqop = r_m[1][MAG_W-1:0];
            default: w_sqop = r_m[2][MAG_W-1:0];
        endcase
    end

    assign w_rb   = r_res + r_bit;
    assign w_root = r_res[ROOT_W-1:0];
    assign w_qc   = (r_q > Q_CLAMP) ? Q_CLAMP : r_q;
    assign w_qs   = w_sgn_sel ? -$signed(w_qc) : $signed(w_qc);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: r_item <= i_in_data;
            OP_POS_CAP: begin
                case (i_cmd.sel)
                    2'd0:    r_pa <= w_pos_rd;
                    2'd1:    r_pb <= w_pos_rd;
                    default: r_pc <= w_pos_rd;
                endcase
            end
            OP_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e0[k] <= sx(r_pb[k*COORD_BITS +: COORD_BITS])
                             - sx(r_pa[k*COORD_BITS +: COORD_BITS]);
                    r_e1[k] <= sx(r_pc[k*COORD_BITS +: COORD_BITS])
                             - sx(r_pa[k*COORD_BITS +: COORD_BITS]);
                end
            end
            OP_MUL: r_cprod <= w_ma * w_mb;
            OP_CR_ACC: begin
                case (i_cmd.step)
                    3'd0:    r_cr[0] <= w_cext;
                    3'd1:    r_cr[0] <= r_cr[0] - w_cext;
                    3'd2:    r_cr[1] <= w_cext;
                    3'd3:    r_cr[1] <= r_cr[1] - w_cext;
                    3'd4:    r_cr[2] <= w_cext;
                    default: r_cr[2] <= r_cr[2] - w_cext;
                endcase
            end
            OP_Q_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_sgn[k] <= w_s[k][SUM_BITS-1];
                    r_m[k]   <= w_s[k][SUM_BITS-1] ? -w_s[k] : w_s[k];
                end
                r_sat <= w_sum_rd[SRW-1];
                r_acc <= '0;
            end
            OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k] <= (|w_big[SUM_BITS-1:NORM_HI]) ? (r_m[k] >> 1) : (r_m[k] << 1);
                end
            end
            OP_SQ_MUL: r_sq <= w_sqop * w_sqop;
            OP_SQ_ACC: r_acc <= r_acc + ACC_W'(r_sq);
            OP_SQRT_INIT: begin
                r_x   <= r_acc;
                r_res <= '0;
                r_bit <= SQRT_BIT0;
            end
            OP_SQRT: begin
                if (r_x >= w_rb) begin
                    r_x   <= r_x - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DIV_INIT: begin
                r_rem  <= (DIV_W'(w_msel) << Q_FRAC) + DIV_W'(w_root);
                r_dsh  <= DIV_W'({w_root, 1'b0}) << Q_FRAC;
                r_qbit <= QBIT0;
                r_q    <= '0;
            end
            OP_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= r_q | r_qbit;
                end
                r_dsh  <= r_dsh >> 1;
                r_qbit <= r_qbit >> 1;
            end
            OP_DIV_STORE: begin
                case (i_cmd.sel)
                    2'd0:    r_n[0] <= w_qs;
                    2'd1:    r_n[1] <= w_qs;
                    default: r_n[2] <= w_qs;
                endcase
            end
            OP_OUT: begin
                r_out <= '{norm_x: r_n[0], norm_y: r_n[1], norm_z: r_n[2],
                           used_default: 1'b0, bad_index: 1'b0, saturated: r_sat};
            end
            OP_OUT_DEF: begin
                r_out <= '{norm_x: '0, norm_y: Q_ONE, norm_z: '0,
                           used_default: 1'b1, bad_index: 1'b0, saturated: r_sat};
            end
            OP_OUT_BAD: begin
                r_out <= '{norm_x: '0, norm_y: '0, norm_z: '0,
                           used_default: 1'b0, bad_index: 1'b1, saturated: 1'b0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.op == OP_CLEAR) begin
                r_count <= '0;
            end
            if ((i_cmd.op == OP_OUT) || (i_cmd.op == OP_OUT_DEF) ||
                (i_cmd.op == OP_OUT_BAD)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.func      = r_item.func;
    assign o_sts.full      = w_full;
    assign o_sts.tri_bad   = (w_ia >= w_cnt) || (w_ib >= w_cnt) || (w_ic >= w_cnt);
    assign o_sts.q_bad     = (w_ia >= w_cnt);
    assign o_sts.big_zero  = (w_big == '0);
    assign o_sts.need_norm = (|w_big[SUM_BITS-1:NORM_HI]) || !(|w_big[SUM_BITS-1:NORM_LO]);
    assign o_sts.sqrt_last = r_bit[0];
    assign o_sts.div_last  = r_qbit[0];
    assign o_sts.out_full  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/vertex_normal_accumulator_unit.sv =====
// Top level of the vertex normal accumulator.
// Depends on vna_pkg, vna_ctrl, vna_dp and vna_ram.

// The unit builds area-weighted vertex normals in fixed point and takes one
// item at a time. A load transfer stores a position in the next vertex slot and
// clears that slot's sum; it is ignored once MAX_VERTICES slots are filled. A
// triangle transfer adds (b-a) x (c-a) with saturation to the sums of all three
// corners and is skipped if any corner is not below the vertex count. A query
// transfer produces one result, the vertex sum scaled to unit length in Q1.14,
// or (0,16384,0) with used_default for a zero sum, or bad_index for an index not
// below the vertex count. A new mesh transfer resets the vertex count. A triangle
// reads the three positions one at a time from the position memory, which has a
// single read port, forms the cross product on one shared multiplier, and does a
// read-modify-write of the three sums. A query first shifts the sum into range if
// needed, then runs a 32-step square root and three 16-step divisions on a single
// divider; a zero sum skips the square root and divisions, and a bad index skips
// all arithmetic. A result sits in an output register, so a new item is taken
// while it waits; a query that finishes while the previous result is still stalled
// waits for that transfer.
module vertex_normal_accumulator_unit import vna_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16,
    parameter int SUM_BITS     = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences each item; it only accepts in its idle state.
    vna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the memories, arithmetic units and the output register.
    vna_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/vna_checker.sv =====
// Port-level checker for the vertex normal accumulator and its bind statement.
// Depends on vna_pkg and vertex_normal_accumulator_unit.
module vna_checker import vna_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // A new result only appears at the end of a query, while input is stalled.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_index |->
            o_out_data.norm_x == 16'sd0 && o_out_data.norm_y == 16'sd0 &&
            o_out_data.norm_z == 16'sd0 && !o_out_data.used_default &&
            !o_out_data.saturated)
        else $error("bad index result not cleared");

    a_default_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.used_default |->
            o_out_data.norm_x == 16'sd0 && o_out_data.norm_y == Q_ONE &&
            o_out_data.norm_z == 16'sd0 && !o_out_data.bad_index)
        else $error("default result is not the up vector");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.norm_x <= Q_ONE && o_out_data.norm_x >= -Q_ONE &&
            o_out_data.norm_y <= Q_ONE && o_out_data.norm_y >= -Q_ONE &&
            o_out_data.norm_z <= Q_ONE && o_out_data.norm_z >= -Q_ONE)
        else $error("normal component out of range");

endmodule

bind vertex_normal_accumulator_unit vna_checker u_vna_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
